@@ hdl/nls_pkg.sv @@
// shared types and constants for the nv12 letterbox rgb sampler
// no dependencies
package nls_pkg;

  localparam int unsigned DIM_W  = 12;  // geometry register width
  localparam int unsigned ADDR_W = 24;  // internal byte address width
  localparam int unsigned DIVN_W = 24;  // divider dividend / quotient width
  localparam int unsigned DIVD_W = 13;  // divider divisor width
  localparam int unsigned ACC_W  = 20;  // color accumulator width
  localparam int unsigned MAX_DIM = 2048;  // largest geometry register value

  localparam logic [7:0] PAD_VALUE = 8'd114;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_ROW_STRIDE   = 3'd2,
    REG_PLANE_ROWS   = 3'd3,
    REG_MODEL_WIDTH  = 3'd4,
    REG_MODEL_HEIGHT = 3'd5
  } reg_idx_e;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_PIXEL = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [22:0] byte_addr;
    logic [7:0]  byte_value;
    logic [10:0] dst_x;
    logic [10:0] dst_y;
  } in_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_image;
  } out_rsp_t;

  // frame memory port request
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_G_MUL0,
    S_G_MUL1,
    S_G_MULW,
    S_G_DIVW,
    S_G_WAITW,
    S_G_MULH,
    S_G_DIVH,
    S_G_WAITH,
    S_P_CHECK,
    S_P_DIVX,
    S_P_WAITX,
    S_P_MULY,
    S_P_DIVY,
    S_P_WAITY,
    S_P_MULA,
    S_P_RDY,
    S_P_MULC,
    S_P_CADDR,
    S_P_RDU,
    S_P_RDV,
    S_P_LATV,
    S_P_SUM,
    S_P_CLAMP,
    S_OUT
  } state_e;

  // floor(v / 256) clamped to a byte
  function automatic logic [7:0] clamp_byte(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-9:0] s;
    s = v[ACC_W-1:8];
    if (s < 0) begin
      clamp_byte = 8'd0;
    end else if (s > 255) begin
      clamp_byte = 8'd255;
    end else begin
      clamp_byte = s[7:0];
    end
  endfunction

endpackage

@@ hdl/nls_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on nls_pkg
module nls_div
  import nls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVN_W-1:0] dividend_i,
  input  logic [DIVD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVN_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quo_q, quo_d;
  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W:0]   trial;

  // one restoring step
  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DIVN_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CNT_W'(DIVN_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[DIVD_W]) begin
        rem_d = trial[DIVD_W-1:0];
        quo_d = {quo_q[DIVN_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIVD_W-1:0];
        quo_d = {quo_q[DIVN_W-2:0], 1'b0};
      end
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/nls_mem.sv @@
// single port frame memory, registered read, out of range reads give zero
// depends on nls_pkg
module nls_mem
  import nls_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 8388608
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);

  logic [7:0] mem_q [MAX_FRAME_BYTES];
  logic [7:0] rd_q;
  logic       oob_q;
  logic       in_range;

  assign in_range = 32'(req_i.addr) < MAX_FRAME_BYTES;

  // write and read port
  always_ff @(posedge clk_i) begin
    if (req_i.we && in_range) begin
      mem_q[AW'(req_i.addr)] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q  <= mem_q[AW'(req_i.addr)];
      oob_q <= !in_range;
    end
  end

  assign rdata_o = oob_q ? 8'd0 : rd_q;

endmodule

@@ hdl/nv12_letterbox_rgb_sampler_unit.sv @@
// nv12 letterbox rgb sampler, top level
// depends on nls_pkg, nls_div, nls_mem
//
// Usage: requests arrive on in_valid_i/in_ready_o as in_req_t. A write request
// stores one NV12 byte in the frame memory and gives no result.
// A pixel request gives one out_rsp_t on out_valid_o/out_ready_i: the
// letterboxed model pixel, converted with BT.601 integer math, or grey padding.
// Geometry (scale, resized sizes, pads) is cached and recomputed on the first
// pixel request after any register write, using two 24-step divides. A pixel
// inside the image needs two 24-step divides for the source coordinates and
// three reads of the single frame memory port; a padding pixel needs neither.
// One request is in flight at a time; a finished result sits in the output
// register, and the next request is taken while it waits. If the
// receiver stalls with a result still held, the following pixel waits in
// its last step until the register frees. Configuration writes on
// cfg_valid_i/cfg_addr_i/cfg_data_i are always taken. Reset restores register
// defaults and clears all handshake state; the frame memory is undefined
// until written.
module nv12_letterbox_rgb_sampler_unit
  import nls_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 8388608
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_rsp_t         out_rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_addr_i,
  input  logic [DIM_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [DIM_W-1:0] sw_q, sh_q, stride_q, prows_q, mw_q, mh_q;
  logic [DIM_W-1:0] cfg_sat;
  logic             dirty_q, dirty_d;

  logic [DIM_W-1:0] num_q, num_d, den_q, den_d;
  logic [DIM_W-1:0] rw_q, rw_d, rh_q, rh_d, xpad_q, xpad_d, ypad_q, ypad_d;
  logic [ADDR_W-1:0] t_q, t_d, t2_q, t2_d, caddr_q, caddr_d;
  logic [10:0] dx_q, dx_d, dy_q, dy_d;
  logic [DIM_W-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [10:0] sx_q, sx_d, sy_q, sy_d;
  logic [7:0]  y_q, y_d, u_q, u_d, v_q, v_d;
  logic signed [ACC_W-1:0] r_acc_q, r_acc_d, g_acc_q, g_acc_d, b_acc_q, b_acc_d;
  out_rsp_t res_q, res_d;
  out_rsp_t out_q, out_d;
  logic     out_valid_q, out_valid_d;

  logic [DIM_W-1:0]   mul_a, mul_b;
  logic [2*DIM_W-1:0] prod;

  logic              div_start;
  logic [DIVN_W-1:0] div_dividend;
  logic [DIVD_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVN_W-1:0] div_quo;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  logic in_acc;
  logic zero_size;
  logic [DIM_W-1:0] qclamp;
  logic [8:0] c_val;
  logic signed [9:0] d_val, e_val;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign zero_size   = (sw_q == '0) || (sh_q == '0) || (mw_q == '0) || (mh_q == '0);

  // register write with saturation
  assign cfg_sat = (32'(cfg_data_i) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q     <= DIM_W'(640);
      sh_q     <= DIM_W'(480);
      stride_q <= DIM_W'(640);
      prows_q  <= DIM_W'(480);
      mw_q     <= DIM_W'(640);
      mh_q     <= DIM_W'(640);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_SRC_WIDTH:    sw_q     <= cfg_sat;
        REG_SRC_HEIGHT:   sh_q     <= cfg_sat;
        REG_ROW_STRIDE:   stride_q <= cfg_sat;
        REG_PLANE_ROWS:   prows_q  <= cfg_sat;
        REG_MODEL_WIDTH:  mw_q     <= cfg_sat;
        REG_MODEL_HEIGHT: mh_q     <= cfg_sat;
        default: ;
      endcase
    end
  end

  // shared multiplier
  assign prod = mul_a * mul_b;

  nls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  nls_mem #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign c_val = (y_q > 8'd16) ? {1'b0, y_q - 8'd16} : 9'd0;
  assign d_val = $signed({2'b00, u_q}) - 10'sd128;
  assign e_val = $signed({2'b00, v_q}) - 10'sd128;

  // sequencer
  always_comb begin
    state_d      = state_q;
    dirty_d      = dirty_q;
    num_d        = num_q;
    den_d        = den_q;
    rw_d         = rw_q;
    rh_d         = rh_q;
    xpad_d       = xpad_q;
    ypad_d       = ypad_q;
    t_d          = t_q;
    t2_d         = t2_q;
    caddr_d      = caddr_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    rx_d         = rx_q;
    ry_d         = ry_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    y_d          = y_q;
    u_d          = u_q;
    v_d          = v_q;
    r_acc_d      = r_acc_q;
    g_acc_d      = g_acc_q;
    b_acc_d      = b_acc_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mem_req      = '0;
    qclamp       = '0;
    if (cfg_valid_i) begin
      dirty_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        res_d = '{red: PAD_VALUE, green: PAD_VALUE, blue: PAD_VALUE, in_image: 1'b0};
        if (in_acc) begin
          dx_d = in_req_i.dst_x;
          dy_d = in_req_i.dst_y;
          if (in_req_i.req_type == REQ_WRITE) begin
            mem_req.we    = 1'b1;
            mem_req.addr  = ADDR_W'(in_req_i.byte_addr);
            mem_req.wdata = in_req_i.byte_value;
          end else if (zero_size) begin
            state_d = S_OUT;
          end else if (dirty_q) begin
            state_d = S_G_MUL0;
          end else begin
            state_d = S_P_CHECK;
          end
        end
      end
      // pick the limiting side
      S_G_MUL0: begin
        mul_a   = mw_q;
        mul_b   = sh_q;
        t_d     = prod;
        dirty_d = cfg_valid_i;
        state_d = S_G_MUL1;
      end
      S_G_MUL1: begin
        mul_a = mh_q;
        mul_b = sw_q;
        if (t_q <= prod) begin
          num_d = mw_q;
          den_d = sw_q;
        end else begin
          num_d = mh_q;
          den_d = sh_q;
        end
        state_d = S_G_MULW;
      end
      // resized width
      S_G_MULW: begin
        mul_a   = sw_q;
        mul_b   = num_q;
        t_d     = prod;
        state_d = S_G_DIVW;
      end
      S_G_DIVW: begin
        div_start    = 1'b1;
        div_dividend = {t_q[DIVN_W-2:0], 1'b0} + DIVN_W'(den_q);
        div_divisor  = {den_q, 1'b0};
        state_d      = S_G_WAITW;
      end
      S_G_WAITW: begin
        if (div_done) begin
          rw_d    = (div_quo == '0) ? DIM_W'(1) : div_quo[DIM_W-1:0];
          state_d = S_G_MULH;
        end
      end
      // resized height and pads
      S_G_MULH: begin
        mul_a   = sh_q;
        mul_b   = num_q;
        t_d     = prod;
        xpad_d  = (mw_q - rw_q) >> 1;
        state_d = S_G_DIVH;
      end
      S_G_DIVH: begin
        div_start    = 1'b1;
        div_dividend = {t_q[DIVN_W-2:0], 1'b0} + DIVN_W'(den_q);
        div_divisor  = {den_q, 1'b0};
        state_d      = S_G_WAITH;
      end
      S_G_WAITH: begin
        if (div_done) begin
          rh_d    = (div_quo == '0) ? DIM_W'(1) : div_quo[DIM_W-1:0];
          ypad_d  = (mh_q - rh_d) >> 1;
          state_d = S_P_CHECK;
        end
      end
      // letterbox bounds, then source column
      S_P_CHECK: begin
        rx_d = DIM_W'(dx_q) - xpad_q;
        ry_d = DIM_W'(dy_q) - ypad_q;
        if ((DIM_W'(dx_q) < xpad_q) || (rx_d >= rw_q) ||
            (DIM_W'(dy_q) < ypad_q) || (ry_d >= rh_q)) begin
          state_d = S_OUT;
        end else begin
          mul_a   = rx_d;
          mul_b   = den_q;
          t_d     = prod;
          state_d = S_P_DIVX;
        end
      end
      S_P_DIVX: begin
        div_start    = 1'b1;
        div_dividend = t_q;
        div_divisor  = DIVD_W'(num_q);
        state_d      = S_P_WAITX;
      end
      S_P_WAITX: begin
        if (div_done) begin
          qclamp = DIM_W'(sw_q - 1'b1);
          if (div_quo > DIVN_W'(qclamp)) begin
            sx_d = qclamp[10:0];
          end else begin
            sx_d = div_quo[10:0];
          end
          state_d = S_P_MULY;
        end
      end
      // source row
      S_P_MULY: begin
        mul_a   = ry_q;
        mul_b   = den_q;
        t_d     = prod;
        state_d = S_P_DIVY;
      end
      S_P_DIVY: begin
        div_start    = 1'b1;
        div_dividend = t_q;
        div_divisor  = DIVD_W'(num_q);
        state_d      = S_P_WAITY;
      end
      S_P_WAITY: begin
        if (div_done) begin
          qclamp = DIM_W'(sh_q - 1'b1);
          if (div_quo > DIVN_W'(qclamp)) begin
            sy_d = qclamp[10:0];
          end else begin
            sy_d = div_quo[10:0];
          end
          state_d = S_P_MULA;
        end
      end
      // luma address and read
      S_P_MULA: begin
        mul_a   = DIM_W'(sy_q);
        mul_b   = stride_q;
        t_d     = prod;
        state_d = S_P_RDY;
      end
      S_P_RDY: begin
        mem_req.re   = 1'b1;
        mem_req.addr = t_q + ADDR_W'(sx_q);
        mul_a        = DIM_W'(sy_q >> 1);
        mul_b        = stride_q;
        t_d          = prod;
        state_d      = S_P_MULC;
      end
      S_P_MULC: begin
        y_d     = mem_rdata;
        mul_a   = stride_q;
        mul_b   = prows_q;
        t2_d    = prod;
        state_d = S_P_CADDR;
      end
      S_P_CADDR: begin
        caddr_d = t2_q + t_q + ADDR_W'({sx_q[10:1], 1'b0});
        state_d = S_P_RDU;
      end
      // chroma reads
      S_P_RDU: begin
        mem_req.re   = 1'b1;
        mem_req.addr = caddr_q;
        state_d      = S_P_RDV;
      end
      S_P_RDV: begin
        u_d          = mem_rdata;
        mem_req.re   = 1'b1;
        mem_req.addr = caddr_q + 1'b1;
        state_d      = S_P_LATV;
      end
      S_P_LATV: begin
        v_d     = mem_rdata;
        state_d = S_P_SUM;
      end
      // bt.601 sums
      S_P_SUM: begin
        r_acc_d = ACC_W'(20'sd298 * $signed({1'b0, c_val}) + 20'sd409 * e_val + 20'sd128);
        g_acc_d = ACC_W'(20'sd298 * $signed({1'b0, c_val}) - 20'sd100 * d_val
                         - 20'sd208 * e_val + 20'sd128);
        b_acc_d = ACC_W'(20'sd298 * $signed({1'b0, c_val}) + 20'sd516 * d_val + 20'sd128);
        state_d = S_P_CLAMP;
      end
      S_P_CLAMP: begin
        res_d.red      = clamp_byte(r_acc_q);
        res_d.green    = clamp_byte(g_acc_q);
        res_d.blue     = clamp_byte(b_acc_q);
        res_d.in_image = 1'b1;
        state_d        = S_OUT;
      end
      // hand result to the output register
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    den_q   <= den_d;
    rw_q    <= rw_d;
    rh_q    <= rh_d;
    xpad_q  <= xpad_d;
    ypad_q  <= ypad_d;
    t_q     <= t_d;
    t2_q    <= t2_d;
    caddr_q <= caddr_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    y_q     <= y_d;
    u_q     <= u_d;
    v_q     <= v_d;
    r_acc_q <= r_acc_d;
    g_acc_q <= g_acc_d;
    b_acc_q <= b_acc_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

@@ hdl/nls_checker.sv @@
// port level checks for the sampler top level, with its bind
// depends on nls_pkg
module nls_checker
  import nls_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // padding pixels are always grey
  a_pad_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.in_image |->
      out_rsp_o.red == PAD_VALUE && out_rsp_o.green == PAD_VALUE &&
      out_rsp_o.blue == PAD_VALUE)
    else $error("padding pixel not grey");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // a new result cannot appear straight after a request is taken
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared in the cycle after a request was taken");

endmodule

bind nv12_letterbox_rgb_sampler_unit nls_checker u_nls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

@@ sim/tb.sv @@
// testbench for nv12_letterbox_rgb_sampler_unit: loads small nv12 frames, requests
// letterboxed pixels and checks each response against an internal predictor
// depends on nls_pkg and the rtl of the sampler
`timescale 1ns / 100ps

module tb;
  import nls_pkg::*;

  localparam int unsigned STORE_BYTES = 8388608;
  localparam int unsigned LIMIT_CYCLES = 3000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_req_t in_req;
  out_rsp_t out_rsp;
  logic [2:0] cfg_addr;
  logic [DIM_W-1:0] cfg_data;

  nv12_letterbox_rgb_sampler_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predictor state
  logic [7:0] frame_bytes [int unsigned];
  int unsigned geom [6];
  out_rsp_t pixel_q [$];
  in_req_t request_q [$];
  int errors = 0;
  longint cycles = 0;
  bit hold_in = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int byte_at(longint a);
    if (a >= STORE_BYTES || !frame_bytes.exists(a)) return 0;
    return frame_bytes[a];
  endfunction

  function automatic logic [7:0] sat8(int v);
    int s;
    s = v >>> 8;
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return s[7:0];
  endfunction

  // letterbox geometry shared by prediction and stimulus
  function automatic void letterbox(output longint num, output longint den,
                                    output longint rw, output longint rh,
                                    output longint xp, output longint yp);
    longint sw, sh, mw, mh;
    sw = geom[REG_SRC_WIDTH]; sh = geom[REG_SRC_HEIGHT];
    mw = geom[REG_MODEL_WIDTH]; mh = geom[REG_MODEL_HEIGHT];
    if (mw * sh <= mh * sw) begin num = mw; den = sw; end
    else begin num = mh; den = sh; end
    rw = (2 * sw * num + den) / (2 * den); if (rw < 1) rw = 1;
    rh = (2 * sh * num + den) / (2 * den); if (rh < 1) rh = 1;
    xp = (mw - rw) / 2; yp = (mh - rh) / 2;
  endfunction

  // source byte addresses of a model pixel; returns 0 for padding
  function automatic bit source_addrs(input longint dx, input longint dy,
                                      output longint ya, output longint ca);
    longint num, den, rw, rh, xp, yp, sx, sy, st;
    ya = 0; ca = 0;
    // any zero size pads every pixel
    if (geom[REG_SRC_WIDTH] == 0 || geom[REG_SRC_HEIGHT] == 0 ||
        geom[REG_MODEL_WIDTH] == 0 || geom[REG_MODEL_HEIGHT] == 0) return 0;
    letterbox(num, den, rw, rh, xp, yp);
    if (dx < xp || dx - xp >= rw || dy < yp || dy - yp >= rh) return 0;
    sx = ((dx - xp) * den) / num;
    if (sx > geom[REG_SRC_WIDTH] - 1) sx = geom[REG_SRC_WIDTH] - 1;
    sy = ((dy - yp) * den) / num;
    if (sy > geom[REG_SRC_HEIGHT] - 1) sy = geom[REG_SRC_HEIGHT] - 1;
    st = geom[REG_ROW_STRIDE];
    ya = sy * st + sx;
    ca = st * geom[REG_PLANE_ROWS] + (sy / 2) * st + (sx / 2) * 2;
    return 1;
  endfunction

  // apply one accepted request to the predictor
  task automatic predict_request(input in_req_t r);
    out_rsp_t p;
    longint ya, ca;
    int c, d, e;
    if (r.req_type == REQ_WRITE) begin
      frame_bytes[r.byte_addr] = r.byte_value;
      return;
    end
    p = '{PAD_VALUE, PAD_VALUE, PAD_VALUE, 1'b0};
    if (source_addrs(r.dst_x, r.dst_y, ya, ca)) begin
      c = byte_at(ya) - 16; if (c < 0) c = 0;
      d = byte_at(ca) - 128;
      e = byte_at(ca + 1) - 128;
      p.red = sat8(298 * c + 409 * e + 128);
      p.green = sat8(298 * c - 100 * d - 208 * e + 128);
      p.blue = sat8(298 * c + 516 * d + 128);
      p.in_image = 1'b1;
    end
    pixel_q.push_back(p);
  endtask

  // request driver
  int in_gap = 0;
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if ((!hold_in || pixel_q.size() == 0) && request_q.size() > 0) begin
        in_req <= request_q.pop_front();
        in_valid <= 1'b1;
        in_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
               : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
      end else begin
        in_valid <= 1'b0;
      end
      // response side: short random stalls, a few long ones
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        out_gap = $urandom_range(20, 80);
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_rsp_t w;
    cycles++;
    if (rst_n && in_valid && in_ready) predict_request(in_req);
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        report("unexpected pixel", 1, 0);
      end else begin
        w = pixel_q.pop_front();
        if (out_rsp.red != w.red) report("red", out_rsp.red, w.red);
        if (out_rsp.green != w.green) report("green", out_rsp.green, w.green);
        if (out_rsp.blue != w.blue) report("blue", out_rsp.blue, w.blue);
        if (out_rsp.in_image != w.in_image)
          report("in_image", out_rsp.in_image, w.in_image);
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("nv12_letterbox_rgb_sampler_unit verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (request_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_addr <= idx; cfg_data <= val[DIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    geom[idx] = (val > 2048) ? 2048 : val;
  endtask

  function automatic in_req_t pixel_req(int x, int y);
    in_req_t r;
    r = '0; r.req_type = REQ_PIXEL;
    r.byte_addr = 23'($urandom); r.byte_value = 8'($urandom);
    r.dst_x = 11'(x); r.dst_y = 11'(y);
    return r;
  endfunction

  function automatic in_req_t byte_req(longint a, int v);
    in_req_t r;
    r = '0; r.req_type = REQ_WRITE;
    r.byte_addr = 23'(a); r.byte_value = 8'(v);
    r.dst_x = 11'($urandom); r.dst_y = 11'($urandom);
    return r;
  endfunction

  // byte value for a frame write, extremes only when asked
  function automatic int pick_byte(input bit extreme);
    if (extreme) return ($urandom_range(0, 1) == 0) ? 0 : 255;
    return $urandom_range(0, 255);
  endfunction

  // random pixels: mostly in image, some anywhere; the bytes each one reads
  // are written just before it
  task automatic random_pixels(input int n, input bit extreme);
    longint num, den, rw, rh, xp, yp, ya, ca;
    in_req_t r;
    letterbox(num, den, rw, rh, xp, yp);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0)
        r = pixel_req(xp + $urandom_range(0, rw - 1), yp + $urandom_range(0, rh - 1));
      else if ($urandom_range(0, 1) == 0)
        r = pixel_req($urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        r = pixel_req($urandom_range(0, geom[REG_MODEL_WIDTH]),
                      $urandom_range(0, geom[REG_MODEL_HEIGHT]));
      if (source_addrs(r.dst_x, r.dst_y, ya, ca)) begin
        request_q.push_back(byte_req(ya, pick_byte(extreme)));
        request_q.push_back(byte_req(ca, pick_byte(extreme)));
        request_q.push_back(byte_req(ca + 1, pick_byte(extreme)));
      end
      request_q.push_back(r);
    end
  endtask

  task automatic phase(input int sw, input int sh, input int stride, input int rows,
                       input int mw, input int mh, input int n, input bit extreme);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_ROW_STRIDE, stride);
    write_reg(REG_PLANE_ROWS, rows);
    write_reg(REG_MODEL_WIDTH, mw);
    write_reg(REG_MODEL_HEIGHT, mh);
    random_pixels(n, extreme);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0; cfg_valid = 1'b0;
    in_req = '0; cfg_addr = '0; cfg_data = '0;
    geom = '{640, 480, 640, 480, 640, 640};
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: corners, padding, extremes, last-byte write, unknown index
    request_q.push_back(byte_req(23'h7FFFFF, 8'hFF));
    request_q.push_back(pixel_req(0, 0));
    request_q.push_back(pixel_req(2047, 2047));
    request_q.push_back(pixel_req(639, 639));
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_addr <= 3'd7; cfg_data <= 12'hFFF;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    phase(4, 2, 4, 2, 8, 8, 12, 1);
    phase(1, 1, 1, 1, 1, 1, 4, 1);
    phase(1, 1, 1, 1, 2047, 2047, 6, 0);
    // send each request only once every earlier response is back
    hold_in = 1;
    phase(6, 3, 8, 4, 5, 9, 10, 0);
    hold_in = 0;
    wait_drained();
    phase(7, 5, 4000, 3, 3, 2, 10, 0);
    phase(2048, 1, 2048, 1, 2047, 4, 8, 0);
    phase(1, 40, 1, 40, 3, 2048, 10, 0);
    phase(0, 3, 3, 3, 4, 4, 6, 0);
    phase(3, 3, 3, 3, 0, 4, 6, 0);

    // random geometry phases
    for (int p = 0; p < 14; p++)
      phase($urandom_range(1, 16), $urandom_range(1, 12), $urandom_range(16, 24),
            $urandom_range(12, 20), $urandom_range(1, 2047), $urandom_range(1, 2047),
            32, 0);
    wait_drained();
    if (errors == 0) $display("nv12_letterbox_rgb_sampler_unit verification clean");
    else $display("nv12_letterbox_rgb_sampler_unit verification failed");
    $finish;
  end
endmodule
